// ===== sv/ftw_pkg.sv =====
// shared constants, types and codes of the twister word generator
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package ftw_pkg;

    // store geometry
    localparam int ENTRIES   = 156;
    localparam int WORDS     = 4 * ENTRIES;
    localparam int ENT_W     = $clog2(ENTRIES);
    localparam int WIDX_W    = $clog2(WORDS + 1);
    localparam int MOD_W     = ((ENT_W > 8) ? ENT_W : 8) + 1;
    localparam int ENTRY_W   = 128;
    localparam int HALF_W    = 64;
    localparam int WORD_W    = 32;

    // configuration port
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TAP_W     = 8;
    localparam int SH_W      = 6;

    // seeding recurrence
    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
    localparam int                SEED_SHR  = 30;

    typedef enum logic {
        OP_SEED  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_OFFSET   = 2'd0,
        CFG_LEFT_SHIFT_A = 2'd1,
        CFG_LEFT_SHIFT_B = 2'd2,
        CFG_RIGHT_SHIFT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TAP_W-1:0] tap_offset;
        logic [SH_W-1:0]  left_shift_a;
        logic [SH_W-1:0]  left_shift_b;
        logic [SH_W-1:0]  right_shift;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] seed;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_q_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_ADD,
        ST_SEED_MUL,
        ST_RG_INIT,
        ST_RG_MOD,
        ST_RG_RD,
        ST_RG_LO,
        ST_RG_HI,
        ST_F_OUT
    } eng_state_t;

endpackage

// ===== sv/ftw_cmd_queue.sv =====
// front end: accepts command words, classifies them and holds them in a
// two-entry queue for the engine; depends on ftw_pkg
`timescale 1ns / 1ps

module ftw_cmd_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [ftw_pkg::WORD_W-1:0] s_seed_value,
    output ftw_pkg::cmd_q_t            head,
    input  logic                       pop
);
    import ftw_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop_ok;
    cmd_t       in_cmd;

    // classify: the seed word only matters for a seed command
    always_comb begin
        in_cmd.op   = op_t'(s_opcode);
        in_cmd.seed = (in_cmd.op == OP_SEED) ? s_seed_value : '0;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop_ok  = pop && (cnt_reg != 2'd0);

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop_ok;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop_ok};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== sv/ftw_engine.sv =====
// back end: entry store, seeding sequencer, in-place regeneration and
// word output register; depends on ftw_pkg
`timescale 1ns / 1ps

module ftw_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ftw_pkg::cfg_t              cfg,
    input  ftw_pkg::cmd_q_t            cmd_q,
    output logic                       cmd_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ftw_pkg::WORD_W-1:0] m_random_word
);
    import ftw_pkg::*;

    eng_state_t state_reg, state_next;

    // entry store with per-entry valid bits (invalid reads as zero)
    logic [ENTRY_W-1:0] entry_store_reg [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    logic [ENTRY_W-1:0] qa_reg, qb_reg;
    logic               qa_vld_reg, qb_vld_reg;

    logic [WIDX_W-1:0]  idx_reg;
    logic [WIDX_W-1:0]  wcnt_reg;
    logic [ENT_W-1:0]   ent_reg;
    logic [MOD_W-1:0]   m_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [WORD_W-1:0]  mul_reg;
    logic [95:0]        buf_reg;
    logic [1:0]         sel_reg;
    logic [ENTRY_W-1:0] prev_reg;
    logic [HALF_W-1:0]  lo_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_word_reg;

    // control decoded from the state
    logic               rda_en, rdb_en, wr_en, out_load;
    logic [ENT_W-1:0]   rda_addr, rdb_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // datapath values
    logic               is_fetch, need_regen, out_free;
    logic [WORD_W-1:0]  seed_word;
    logic [ENTRY_W-1:0] cur, tapv;
    logic [HALF_W-1:0]  lo_new, hi_new, tap_lo_h;
    logic               m_is_i, last_ent;
    logic [MOD_W-1:0]   m_inc;

    assign is_fetch   = (cmd_q.cmd.op == OP_FETCH);
    assign need_regen = (idx_reg >= WIDX_W'(WORDS));
    assign out_free   = !out_valid_reg || m_ready;
    assign last_ent   = (ent_reg == ENT_W'(ENTRIES - 1));

    // seeding word: the seed itself first, then product plus index
    assign seed_word = (wcnt_reg == '0) ? word_reg : (mul_reg + WORD_W'(wcnt_reg));

    // regeneration arithmetic on the registered reads
    assign cur      = qa_vld_reg ? qa_reg : '0;
    assign tapv     = qb_vld_reg ? qb_reg : '0;
    assign m_is_i   = (m_reg == MOD_W'(ent_reg));
    assign tap_lo_h = m_is_i ? lo_reg : tapv[HALF_W-1:0];
    assign m_inc    = (m_reg == MOD_W'(ENTRIES - 1)) ? '0 : (m_reg + 1'b1);

    assign lo_new = cur[HALF_W-1:0] ^ (cur[HALF_W-1:0] << cfg.left_shift_a)
                  ^ tapv[HALF_W-1:0] ^ (tapv[ENTRY_W-1:HALF_W] >> cfg.right_shift)
                  ^ prev_reg[HALF_W-1:0] ^ (prev_reg[ENTRY_W-1:HALF_W] << cfg.left_shift_b);

    assign hi_new = cur[ENTRY_W-1:HALF_W] ^ (lo_reg << cfg.left_shift_a)
                  ^ tapv[ENTRY_W-1:HALF_W] ^ (tap_lo_h >> cfg.right_shift)
                  ^ prev_reg[ENTRY_W-1:HALF_W] ^ (prev_reg[HALF_W-1:0] << cfg.left_shift_b);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_q.valid) begin
                    if (!is_fetch) begin
                        state_next = ST_SEED_ADD;
                    end else if (need_regen) begin
                        state_next = ST_RG_INIT;
                    end else begin
                        state_next = ST_F_OUT;
                    end
                end
            end
            ST_SEED_ADD: begin
                state_next = (wcnt_reg == WIDX_W'(WORDS - 1)) ? ST_IDLE : ST_SEED_MUL;
            end
            ST_SEED_MUL: state_next = ST_SEED_ADD;
            ST_RG_INIT:  state_next = ST_RG_MOD;
            ST_RG_MOD: begin
                if (m_reg < MOD_W'(ENTRIES)) begin
                    state_next = ST_RG_RD;
                end
            end
            ST_RG_RD: state_next = ST_RG_LO;
            ST_RG_LO: state_next = ST_RG_HI;
            ST_RG_HI: state_next = last_ent ? ST_IDLE : ST_RG_RD;
            ST_F_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        cmd_pop  = 1'b0;
        rda_en   = 1'b0;
        rdb_en   = 1'b0;
        rda_addr = '0;
        rdb_addr = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_q.valid && !is_fetch) begin
                    cmd_pop = 1'b1;
                end else if (cmd_q.valid && !need_regen) begin
                    cmd_pop  = 1'b1;
                    rda_en   = 1'b1;
                    rda_addr = idx_reg[ENT_W+1:2];
                end
            end
            ST_SEED_ADD: begin
                wr_en   = (wcnt_reg[1:0] == 2'd3);
                wr_addr = wcnt_reg[ENT_W+1:2];
                wr_data = {seed_word, buf_reg};
            end
            ST_RG_INIT: begin
                rda_en   = 1'b1;
                rda_addr = ENT_W'(ENTRIES - 1);
            end
            ST_RG_RD: begin
                rda_en   = 1'b1;
                rda_addr = ent_reg;
                rdb_en   = 1'b1;
                rdb_addr = m_reg[ENT_W-1:0];
            end
            ST_RG_HI: begin
                wr_en   = 1'b1;
                wr_addr = ent_reg;
                wr_data = {hi_new, lo_reg};
            end
            ST_F_OUT: out_load = out_free;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && rda_en) begin
                idx_reg <= idx_reg + 1'b1;
            end else if (state_reg == ST_SEED_ADD && state_next == ST_IDLE) begin
                idx_reg <= WIDX_W'(WORDS);
            end else if (state_reg == ST_RG_HI && last_ent) begin
                idx_reg <= '0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (cmd_pop && !is_fetch) begin
                    word_reg <= cmd_q.cmd.seed;
                    wcnt_reg <= '0;
                end
                sel_reg <= idx_reg[1:0];
            end
            ST_SEED_ADD: begin
                word_reg <= seed_word;
                case (wcnt_reg[1:0])
                    2'd0:    buf_reg[31:0]  <= seed_word;
                    2'd1:    buf_reg[63:32] <= seed_word;
                    2'd2:    buf_reg[95:64] <= seed_word;
                    default: ;
                endcase
                wcnt_reg <= wcnt_reg + 1'b1;
            end
            ST_SEED_MUL: begin
                mul_reg <= SEED_MULT * (word_reg ^ (word_reg >> SEED_SHR));
            end
            ST_RG_INIT: begin
                m_reg   <= MOD_W'(cfg.tap_offset);
                ent_reg <= '0;
            end
            ST_RG_MOD: begin
                // wrap the tap distance into the store, one subtract a cycle
                if (m_reg >= MOD_W'(ENTRIES)) begin
                    m_reg <= m_reg - MOD_W'(ENTRIES);
                end
                prev_reg <= cur;
            end
            ST_RG_LO: lo_reg <= lo_new;
            ST_RG_HI: begin
                prev_reg <= {hi_new, lo_reg};
                ent_reg  <= ent_reg + 1'b1;
                m_reg    <= m_inc;
            end
            default: ;
        endcase
        if (out_load) begin
            out_word_reg <= cur[{sel_reg, 5'd0} +: WORD_W];
        end
    end

    // store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_store_reg[wr_addr] <= wr_data;
        end
        if (rda_en) begin
            qa_reg     <= entry_store_reg[rda_addr];
            qa_vld_reg <= vld_reg[rda_addr];
        end
        if (rdb_en) begin
            qb_reg     <= entry_store_reg[rdb_addr];
            qb_vld_reg <= vld_reg[rdb_addr];
        end
    end

    // valid bits stand in for clearing the store at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_random_word = out_word_reg;

`ifndef SYNTH
    a_regen_restarts_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RG_HI && last_ent) |=> (idx_reg == '0))
        else $error("index not restarted after regeneration");

    a_seed_marks_used_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED_ADD && wcnt_reg == WIDX_W'(WORDS - 1))
        |=> (idx_reg == WIDX_W'(WORDS)))
        else $error("store not marked used up after seeding");

    a_fetch_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && is_fetch) |-> (idx_reg < WIDX_W'(WORDS)))
        else $error("fetch issued past the end of the store");

    a_tap_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RG_RD) |-> (m_reg < MOD_W'(ENTRIES)))
        else $error("tap entry outside the store");
`endif

endmodule

// ===== sv/fast_twister_word_generator.sv =====
// Twister word generator over a store of 128-bit entries.
// Input channel s_*: one command word per handshake, s_opcode 0 seeds
// the store from s_seed_value (no result), s_opcode 1 fetches the next
// 32-bit word, which leaves on the m_* channel.
// Commands enter a two-entry queue, so the input side keeps accepting
// while a fetched word waits in the output register for m_ready.
// A fetch reads its entry from the store, then loads the selected
// word into the output register once that register is free.
// Every 4*ENTRIES words the next fetch first regenerates the store in
// place, one entry at a time: each entry is read, its low half computed
// and the whole entry written back through the store's ports.
// A seed computes all words one at a time through the multiplier
// register and writes them to the store four words to an entry.
// Reset (aresetn, synchronous, low) empties the queue and output, sets
// the control and configuration registers to their defaults and marks
// every entry as zero through per-entry valid bits; no clearing pass is needed.
// cfg_we writes cfg_wdata into register cfg_index; write only while
// the block is idle. Depends on ftw_pkg, ftw_cmd_queue, ftw_engine.
`timescale 1ns / 1ps

module fast_twister_word_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ftw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ftw_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [ftw_pkg::WORD_W-1:0]    s_seed_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ftw_pkg::WORD_W-1:0]    m_random_word
);
    import ftw_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    cmd_q_t cmd_q;
    logic   cmd_pop;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TAP_OFFSET:   cfg_next.tap_offset   = cfg_wdata[TAP_W-1:0];
                CFG_LEFT_SHIFT_A: cfg_next.left_shift_a = cfg_wdata[SH_W-1:0];
                CFG_LEFT_SHIFT_B: cfg_next.left_shift_b = cfg_wdata[SH_W-1:0];
                CFG_RIGHT_SHIFT:  cfg_next.right_shift  = cfg_wdata[SH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_offset   <= TAP_W'(1);
            cfg_reg.left_shift_a <= SH_W'(11);
            cfg_reg.left_shift_b <= SH_W'(7);
            cfg_reg.right_shift  <= SH_W'(17);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end queue
    ftw_cmd_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_seed_value (s_seed_value),
        .head         (cmd_q),
        .pop          (cmd_pop)
    );

    // back end engine
    ftw_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd_q         (cmd_q),
        .cmd_pop       (cmd_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word)
    );

endmodule
